// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the multiset count table.
// Every macro samples on clk and is disabled while rst_n is low.
// Compiling with NO_ASSERTIONS defined turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/mct_pkg.sv =====
// Package for the multiset count table: sizes, opcode and status codes,
// and the sequencer state type. It depends on nothing else.
package mct_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int SCAN_W  = $clog2(SLOTS + 1);
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int ENTRY_W = VALUE_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LOOKUP = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESULT
    } state_t;

endpackage

// ===== design/multiset_count_table.sv =====
// Multiset count table: a bounded multiset of (value, repeat count) slots.
// Insert, remove and lookup scan one slot per cycle and stop at the first hit; a clear
// skips the scan. A new item is taken only once the last result has moved into the
// output register; a stalled result holds.
// Asynchronous active-low reset marks every slot free and empties the output register;
// the slot memory itself is not cleared, since a free slot is never compared.
`include "assert_macros.svh"

module multiset_count_table
    import mct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                opcode,
    input  logic signed [VALUE_W-1:0] item_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COUNT_W-1:0]        item_count,
    output logic                      table_empty,
    output logic [1:0]                status
);

    // Sequencer state.
    state_t state_reg, state_next;

    // The item being worked on.
    opcode_t              op_reg, op_next;
    logic [VALUE_W-1:0]   value_reg, value_next;

    // Scan pipeline: scan_idx_reg is the address read this cycle, and
    // cmp_idx_reg names the entry whose data sits in rd_data_reg.
    logic [SCAN_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;

    // What the scan found: the slot holding the value, and the lowest free slot.
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;

    // One occupancy bit per slot, and the number of occupied slots.
    logic [SLOTS-1:0]     occ_reg, occ_next;
    logic [SCAN_W-1:0]    occ_cnt_reg, occ_cnt_next;

    // Result waiting for the output register.
    logic [COUNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic                 res_empty_reg, res_empty_next;
    status_t              res_status_reg, res_status_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic                 out_empty_reg, out_empty_next;
    status_t              out_status_reg, out_status_next;

    // Slot memory: each word holds the count above the value.
    logic [ENTRY_W-1:0]   slot_mem [SLOTS];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    logic                 in_xfer;
    logic                 load_out;
    logic [VALUE_W-1:0]   rd_value;
    logic [COUNT_W-1:0]   rd_count;
    logic                 cmp_occ;
    logic                 hit_now;
    logic                 scan_last;
    logic [COUNT_W-1:0]   inc_cnt;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign load_out  = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);

    // The shared compare unit looks at one slot per cycle.
    assign rd_value  = rd_data_reg[VALUE_W-1:0];
    assign rd_count  = rd_data_reg[ENTRY_W-1:VALUE_W];
    assign cmp_occ   = occ_reg[cmp_idx_reg];
    assign hit_now   = cmp_vld_reg && cmp_occ && (rd_value == value_reg);
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == IDX_W'(SLOTS - 1));

    // A read is issued for every slot address until the scan ends on a hit or runs off the end.
    assign rd_en     = (state_reg == S_SCAN) && (scan_idx_reg < SCAN_W'(SLOTS));
    assign rd_addr   = scan_idx_reg[IDX_W-1:0];

    // The count saturates rather than wrapping.
    assign inc_cnt   = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg : hit_cnt_reg + COUNT_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode_t'(opcode) == OP_CLEAR)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit_now || scan_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and table updates.
    always_comb
    begin
        op_next         = op_reg;
        value_next      = value_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        occ_next        = occ_reg;
        occ_cnt_next    = occ_cnt_reg;
        res_cnt_next    = res_cnt_reg;
        res_empty_next  = res_empty_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = hit_idx_reg;
        wr_data         = {inc_cnt, value_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next         = opcode_t'(opcode);
                    value_next      = item_value;
                    scan_idx_next   = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    if (opcode_t'(opcode) == OP_CLEAR)
                    begin
                        // Clearing needs no scan: all occupancy bits drop at once.
                        occ_next        = '0;
                        occ_cnt_next    = '0;
                        res_cnt_next    = '0;
                        res_empty_next  = 1'b1;
                        res_status_next = ST_OK;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    scan_idx_next = scan_idx_reg + SCAN_W'(1);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = rd_addr;
                end
                if (hit_now)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_cnt_next = rd_count;
                end
                if (cmp_vld_reg && !cmp_occ && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
            end
            S_UPDATE:
            begin
                res_cnt_next    = '0;
                res_status_next = ST_OK;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            wr_en        = 1'b1;
                            res_cnt_next = inc_cnt;
                        end
                        else if (free_found_reg)
                        begin
                            wr_en                 = 1'b1;
                            wr_addr               = free_idx_reg;
                            wr_data               = {COUNT_W'(1), value_reg};
                            occ_next[free_idx_reg] = 1'b1;
                            occ_cnt_next          = occ_cnt_reg + SCAN_W'(1);
                            res_cnt_next          = COUNT_W'(1);
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            occ_next[hit_idx_reg] = 1'b0;
                            occ_cnt_next          = occ_cnt_reg - SCAN_W'(1);
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            res_cnt_next = hit_cnt_reg;
                        end
                    end
                    default:
                    begin
                        res_cnt_next = '0;
                    end
                endcase
                res_empty_next = (occ_cnt_next == '0);
            end
            default:
            begin
                cmp_vld_next = 1'b0;
            end
        endcase
    end

    // Output register: a finished result waits here for its transfer.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_cnt_next    = out_cnt_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_cnt_next    = res_cnt_reg;
            out_empty_next  = res_empty_reg;
            out_status_next = res_status_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmp_vld_reg    <= 1'b0;
            occ_reg        <= '0;
            occ_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_vld_reg    <= cmp_vld_next;
            occ_reg        <= occ_next;
            occ_cnt_reg    <= occ_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_cnt_reg    <= hit_cnt_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_cnt_reg    <= res_cnt_next;
        res_empty_reg  <= res_empty_next;
        res_status_reg <= res_status_next;
        out_cnt_reg    <= out_cnt_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

    // Slot memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign item_count  = out_cnt_reg;
    assign table_empty = out_empty_reg;
    assign status      = out_status_reg;

    `ASSERT_ALWAYS(a_occ_cnt_matches, occ_cnt_reg == SCAN_W'($countones(occ_reg)), "occupied count disagrees with occupancy bits")
    `ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_reg != S_IDLE, "sequencer idle right after an input transfer")
    `ASSERT_IMPLIES(a_hit_slot_occupied, (state_reg == S_UPDATE) && hit_reg, occ_reg[hit_idx_reg], "hit recorded on a free slot")
    `ASSERT_IMPLIES(a_full_only_when_full, (state_reg == S_UPDATE) && (op_reg == OP_INSERT) && !hit_reg && !free_found_reg, &occ_reg, "insert dropped while a slot was free")
    `ASSERT_IMPLIES(a_empty_has_no_count, out_valid_reg && out_empty_reg, out_cnt_reg == '0, "empty table reported with a nonzero count")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for multiset_count_table: directed and random phases.
// The expected results come from a shadow copy of the slot table kept in this file.
// Depends on mct_pkg and the multiset_count_table RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mct_pkg::*;

    // Chance that the receiver holds off at a given clock edge, or that the sender holds off
    // before an item, and the longest hold-off run that the sender takes.
    localparam int IDLE_PCT     = 17;
    localparam int MAX_IDLE_RUN = 8;
    // The drain after each phase outlasts the longest pass of an item through the block
    // without output stalls. The watchdog allows many times the slowest legal gap.
    localparam int DRAIN_CYCLES = 2 * (SLOTS + 4);
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int POOL_SIZE    = 24;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               empty;
        status_t            st;
    } table_result_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic [1:0]                opcode     = '0;
    logic signed [VALUE_W-1:0] item_value = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic [COUNT_W-1:0]        item_count;
    logic                      table_empty;
    logic [1:0]                status;

    // Shadow of the slot table. A slot whose count is zero is free.
    logic [VALUE_W-1:0] shadow_value [SLOTS];
    logic [COUNT_W-1:0] shadow_count [SLOTS];
    table_result_t      pending_results [$];

    // Cleared by a test to run both sides at full rate.
    bit idle_on = 1'b1;

    int fail_count     = 0;
    int mismatch_count = 0;
    int sent_count     = 0;
    int seen_count     = 0;
    int full_drops     = 0;
    int remove_misses  = 0;
    int quiet_cycles   = 0;

    multiset_count_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_count  (item_count),
        .table_empty (table_empty),
        .status      (status)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Applies one operation to the shadow table and returns the result the block
    // must produce for it. Values are compared as raw 32-bit patterns.
    function automatic table_result_t table_apply(opcode_t op, logic [VALUE_W-1:0] v);
        table_result_t r;
        int            hit;
        int            spare;
        int            i;
        r.count = '0;
        r.empty = 1'b1;
        r.st    = ST_OK;
        hit     = -1;
        spare   = -1;
        // Walking downward leaves the lowest free slot in spare.
        for (i = SLOTS - 1; i >= 0; i--)
        begin
            if (shadow_count[i] != '0 && shadow_value[i] == v)
                hit = i;
            if (shadow_count[i] == '0)
                spare = i;
        end
        case (op)
            OP_INSERT:
            begin
                if (hit >= 0)
                begin
                    if (shadow_count[hit] != COUNT_MAX)
                        shadow_count[hit] = shadow_count[hit] + 1'b1;
                    r.count = shadow_count[hit];
                end
                else if (spare >= 0)
                begin
                    shadow_value[spare] = v;
                    shadow_count[spare] = COUNT_W'(1);
                    r.count = COUNT_W'(1);
                end
                else
                begin
                    r.st = ST_FULL;
                    full_drops++;
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                    shadow_count[hit] = '0;
                else
                begin
                    r.st = ST_NOT_FOUND;
                    remove_misses++;
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < SLOTS; i++)
                    shadow_count[i] = '0;
            end
            default:
            begin
                // A lookup only reports the current count.
                if (hit >= 0)
                    r.count = shadow_count[hit];
            end
        endcase
        for (i = 0; i < SLOTS; i++)
        begin
            if (shadow_count[i] != '0)
                r.empty = 1'b0;
        end
        return r;
    endfunction

    function automatic void flag_mismatch(string detail);
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("mismatch at %0t ns: %s", $time, detail);
    endfunction

    // Offers one item and returns at the edge where it is transferred. Valid is left
    // high so that a following item can go out back to back; settle() lowers it.
    task automatic send_item(opcode_t op, logic [VALUE_W-1:0] v);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_IDLE_RUN)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        item_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(table_apply(op, v));
        sent_count++;
    endtask

    // Ends a phase: no more items, every expected result in, then a further drain
    // so that nothing is still in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Clear and remove on an empty table, extreme values, a repeat, lookups of present
    // and absent values, and a clear with a nonzero value.
    task automatic test_basic_ops();
        send_item(OP_CLEAR, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_LOOKUP, 32'h7FFF_FFFF);
        send_item(OP_LOOKUP, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
        settle();
    endtask

    // Fills every slot, then checks the full drop, a hit while full, and that a freed
    // slot in the middle is taken by the next new value.
    task automatic test_full_table();
        int k;
        send_item(OP_CLEAR, 32'h0000_0000);
        for (k = 0; k < SLOTS; k++)
            send_item(OP_INSERT, 32'hC000_0000 + k);
        send_item(OP_INSERT, 32'h1234_5678);
        send_item(OP_INSERT, 32'hC000_0005);
        send_item(OP_REMOVE, 32'hC000_0003);
        send_item(OP_INSERT, 32'h1234_5678);
        send_item(OP_LOOKUP, 32'h1234_5678);
        settle();
    endtask

    // Random operations over a small pool of values, so that hits, removes of held
    // values and full drops are common. Some pool entries differ from a neighbor in
    // a single bit, to test the compare on one-bit differences. A stretch in the middle
    // runs without any idling.
    task automatic test_random_mix();
        logic [VALUE_W-1:0] pool [POOL_SIZE];
        logic [VALUE_W-1:0] v;
        opcode_t            op;
        int                 n;
        int                 pick;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (n = 4; n < POOL_SIZE; n++)
        begin
            if (n % 3 == 0)
                pool[n] = pool[n - 1] ^ (32'h1 << $urandom_range(0, VALUE_W - 1));
            else
                pool[n] = $urandom;
        end
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = !(n >= 500 && n < 750);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                op = OP_INSERT;
            else if (pick < 80)
                op = OP_REMOVE;
            else if (pick < 92)
                op = OP_LOOKUP;
            else if (pick < 94)
                op = OP_CLEAR;
            else
                op = OP_INSERT;
            if ($urandom_range(0, 9) == 0)
                v = $urandom;
            else
                v = pool[$urandom_range(0, POOL_SIZE - 1)];
            send_item(op, v);
        end
        settle();
        idle_on = 1'b1;
    endtask

    // The receiver stalls at random unless a test has switched idling off.
    always @(posedge clk)
    begin
        if (!idle_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Each result transfer is matched against the oldest pending expectation.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen_count++;
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("result with nothing pending: count=%0d empty=%0b status=%0d",
                                        item_count, table_empty, status));
            else
            begin
                want = pending_results.pop_front();
                if (item_count !== want.count || table_empty !== want.empty
                    || status !== want.st)
                    flag_mismatch($sformatf({"result %0d: expected count=%0d empty=%0b ",
                                             "status=%0d, got count=%0d empty=%0b status=%0d"},
                                            seen_count, want.count, want.empty, want.st,
                                            item_count, table_empty, status));
            end
        end
    end

    // Ends a run in which neither channel completes a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_full_table();
        test_random_mix();
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("%0d items sent, %0d results checked, %0d mismatches", sent_count,
                 seen_count, mismatch_count);
        $display("%0d full drops and %0d removes of absent values were exercised",
                 full_drops, remove_misses);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
